// File: hw/rtl/assert_macros.svh
// Assertion macros used by the oscillator RTL (polyblep_oscillator).
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PBLEP_ASSERT_AT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define PBLEP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`else

`define PBLEP_ASSERT_AT(label, clk, rst_n, pre, post)
`define PBLEP_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// File: hw/rtl/pblep_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the PolyBLEP oscillator.
// No dependencies; imported by polyblep_oscillator.
package pblep_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int SAMPLE_BITS   = 24;
    localparam int INC_BITS      = 31;
    localparam int RECIP_BITS    = 40;
    localparam int PW_BITS       = 16;
    localparam int VAL_BITS      = 34;   // Q.30 working value, signed
    localparam int Y_BITS        = 31;   // 1 - x, Q.30, at most 1.0
    localparam int CNT_BITS      = 5;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 32;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 40;

    localparam logic [CNT_BITS-1:0]    CNT_LAST  = CNT_BITS'(PHASE_BITS - 1);
    localparam logic [PHASE_BITS-1:0]  HALF_Q32  = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [PHASE_BITS:0]    ONE_Q32   = {1'b1, {PHASE_BITS{1'b0}}};
    localparam logic [Y_BITS-1:0]      ONE30_Y   = {1'b1, {(Y_BITS-1){1'b0}}};
    localparam logic signed [VAL_BITS-1:0] ONE30_V  = VAL_BITS'(64'sd1 << 30);
    localparam logic signed [VAL_BITS-1:0] RND_HALF = VAL_BITS'(64'sd256);
    localparam logic signed [SAMPLE_BITS:0] SAMPLE_MAX =
        (SAMPLE_BITS+1)'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
    localparam logic signed [SAMPLE_BITS:0] SAMPLE_MIN =
        (SAMPLE_BITS+1)'(-(64'sd1 <<< (SAMPLE_BITS-1)));
    localparam logic [PW_BITS-1:0] PW_RESET = 16'h8000;

    typedef enum logic [1:0] {
        WAVE_SAW    = 2'd0,
        WAVE_PULSE  = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_SILENT = 2'd3
    } wave_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WAVE  = 2'd0,
        CFG_INC   = 2'd1,
        CFG_RECIP = 2'd2,
        CFG_PW    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SETUP  = 3'd1,
        ST_MUL1   = 3'd2,
        ST_CLAMP  = 3'd3,
        ST_MUL2   = 3'd4,
        ST_ACCUM  = 3'd5,
        ST_FINISH = 3'd6
    } state_t;

endpackage

// File: hw/rtl/polyblep_oscillator.sv
`timescale 1ns / 1ps
// PolyBLEP band-limited oscillator: sawtooth, pulse and square with edge smoothing.
// Depends on pblep_pkg and assert_macros.svh.
//
// Usage:
//   s_* stream: one beat per output sample; s_tdata[0] is resync (clear phase first).
//   m_* stream: one beat per input beat; m_tdata[23:0] signed Q3.21 sample,
//   m_tdata[24] phase wrap flag.
//   cfg_* port: register writes (wave, increment, reciprocal, pulse width), always
//   ready; write only while the block is idle.
// Timing: one item at a time. Each edge residual runs setup, a first pass of a
//   bit-serial shift-add multiplier, a clamp, a second pass and an add.
//   Silence goes straight to the final state; a sawtooth checks one edge and
//   pulse or square two, each with or without a residual. The final state loads
//   the output register; s_tready rises in the same cycle as m_tvalid, so the
//   next beat can be taken in that same cycle.
// Reset: phase zero, sawtooth, increment and reciprocal zero, pulse width one half.
// Stall: the result sits in an output register; the next beat is accepted and
//   computed, then held in the final state until the output register frees up.
`include "assert_macros.svh"

module polyblep_oscillator (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [pblep_pkg::IN_TDATA_BITS-1:0]    s_tdata,   // [0] resync, [7:1] zero
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [pblep_pkg::OUT_TDATA_BITS-1:0]   m_tdata,   // [23:0] sample, [24] wrapped
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pblep_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pblep_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import pblep_pkg::*;

    // configuration
    wave_t                  wave_reg;
    logic [INC_BITS-1:0]    inc_reg;
    logic [RECIP_BITS-1:0]  recip_reg;
    logic [PW_BITS-1:0]     pw_reg;

    // control and datapath
    state_t                 state_reg, state_next;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic                   wrap_reg, wrap_next;
    logic [PHASE_BITS-1:0]  t_reg, t_next;
    logic [PHASE_BITS-1:0]  arg_reg, arg_next;
    logic                   sel_reg, sel_next;
    logic                   neg_reg, neg_next;
    logic signed [VAL_BITS-1:0] v_reg, v_next;
    logic [RECIP_BITS-1:0]  mcand_reg, mcand_next;
    logic [RECIP_BITS-1:0]  acc_reg, acc_next;
    logic [PHASE_BITS-1:0]  lo_reg, lo_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                   out_wrap_reg, out_wrap_next;

    logic                   accept;
    logic                   out_free;
    logic [PHASE_BITS-1:0]  t_in;
    logic [PHASE_BITS:0]    phase_sum;
    logic [PHASE_BITS-1:0]  pw_q32;
    logic [PHASE_BITS-1:0]  t2;
    logic                   near_start, near_end, more_blep, op_sub;
    logic [PHASE_BITS-1:0]  d_end;
    logic [RECIP_BITS-1:0]  addend;
    logic [RECIP_BITS:0]    mul_sum;
    logic                   x_over;
    logic [Y_BITS-1:0]      q_val, y_val, sq_val;
    logic signed [VAL_BITS-1:0] sq_ext, v_acc, v_rnd, base_v;
    logic signed [SAMPLE_BITS:0] r_val;
    logic [SAMPLE_BITS-1:0] sat_val;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(OUT_TDATA_BITS-SAMPLE_BITS-1)'(0), out_wrap_reg, out_sample_reg};
    assign out_free  = !out_valid_reg || m_tready;

    // phase after optional resync, and its advance
    assign t_in      = s_tdata[0] ? '0 : phase_reg;
    assign phase_sum = {1'b0, t_in} + {{(PHASE_BITS-INC_BITS+1){1'b0}}, inc_reg};
    assign pw_q32    = (wave_reg == WAVE_PULSE) ?
                       {pw_reg, {(PHASE_BITS-PW_BITS){1'b0}}} : HALF_Q32;
    assign t2        = t_reg - pw_q32;

    always_comb begin
        case (wave_reg)
            WAVE_SAW:    base_v = $signed({3'b000, t_in[PHASE_BITS-1:1]}) - ONE30_V;
            WAVE_PULSE,
            WAVE_SQUARE: base_v = (t_in < pw_q32) ? ONE30_V : -ONE30_V;
            default:     base_v = '0;
        endcase
    end

    // residual window around the discontinuity
    assign near_start = ({1'b0, arg_reg} < {2'b00, inc_reg});
    assign near_end   = ({1'b0, arg_reg} > (ONE_Q32 - {2'b00, inc_reg}));
    assign d_end      = PHASE_BITS'(ONE_Q32 - {1'b0, arg_reg});
    assign more_blep  = ((wave_reg == WAVE_PULSE) || (wave_reg == WAVE_SQUARE)) && !sel_reg;
    assign op_sub     = (wave_reg == WAVE_SAW) || sel_reg;

    // one shift-add step: multiplier bits leave lo_reg LSB first, product bits enter at top
    assign addend  = lo_reg[0] ? mcand_reg : '0;
    assign mul_sum = {1'b0, acc_reg} + {1'b0, addend};

    // x = product >> 16, clamped to 1.0 in Q0.32; y = 1 - x in Q.30
    assign x_over = (|acc_reg[RECIP_BITS-1:17]) ||
                    (acc_reg[16] && (|{acc_reg[15:0], lo_reg[31:16]}));
    assign q_val  = x_over ? ONE30_Y : {acc_reg[16:0], lo_reg[31:18]};
    assign y_val  = ONE30_Y - q_val;

    // y*y >> 30
    assign sq_val = {acc_reg[28:0], lo_reg[31:30]};
    assign sq_ext = $signed({3'b000, sq_val});
    assign v_acc  = (neg_reg ^ op_sub) ? (v_reg - sq_ext) : (v_reg + sq_ext);

    // round half up to Q.21, then saturate
    assign v_rnd  = v_reg + RND_HALF;
    assign r_val  = v_rnd[VAL_BITS-1:9];
    always_comb begin
        if (r_val > SAMPLE_MAX) begin
            sat_val = SAMPLE_MAX[SAMPLE_BITS-1:0];
        end else if (r_val < SAMPLE_MIN) begin
            sat_val = SAMPLE_MIN[SAMPLE_BITS-1:0];
        end else begin
            sat_val = r_val[SAMPLE_BITS-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (wave_reg == WAVE_SILENT) ? ST_FINISH : ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (near_start || near_end) begin
                    state_next = ST_MUL1;
                end else if (!more_blep) begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL1: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_MUL2;
            ST_MUL2: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: state_next = more_blep ? ST_SETUP : ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        phase_next      = phase_reg;
        wrap_next       = wrap_reg;
        t_next          = t_reg;
        arg_next        = arg_reg;
        sel_next        = sel_reg;
        neg_next        = neg_reg;
        v_next          = v_reg;
        mcand_next      = mcand_reg;
        acc_next        = acc_reg;
        lo_next         = lo_reg;
        cnt_next        = cnt_reg;
        out_sample_next = out_sample_reg;
        out_wrap_next   = out_wrap_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    phase_next = phase_sum[PHASE_BITS-1:0];
                    wrap_next  = phase_sum[PHASE_BITS];
                    t_next     = t_in;
                    arg_next   = t_in;
                    sel_next   = 1'b0;
                    v_next     = base_v;
                end
            end
            ST_SETUP: begin
                if (near_start || near_end) begin
                    neg_next   = near_start;
                    lo_next    = near_start ? arg_reg : d_end;
                    mcand_next = recip_reg;
                    acc_next   = '0;
                    cnt_next   = '0;
                end else if (more_blep) begin
                    sel_next = 1'b1;
                    arg_next = t2;
                end
            end
            ST_MUL1, ST_MUL2: begin
                acc_next = mul_sum[RECIP_BITS:1];
                lo_next  = {mul_sum[0], lo_reg[PHASE_BITS-1:1]};
                cnt_next = cnt_reg + 1'b1;
            end
            ST_CLAMP: begin
                mcand_next = {{(RECIP_BITS-Y_BITS){1'b0}}, y_val};
                lo_next    = {{(PHASE_BITS-Y_BITS){1'b0}}, y_val};
                acc_next   = '0;
                cnt_next   = '0;
            end
            ST_ACCUM: begin
                v_next = v_acc;
                if (more_blep) begin
                    sel_next = 1'b1;
                    arg_next = t2;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = sat_val;
                    out_wrap_next   = wrap_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg  <= WAVE_SAW;
            inc_reg   <= '0;
            recip_reg <= '0;
            pw_reg    <= PW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_WAVE:  wave_reg  <= wave_t'(cfg_data[1:0]);
                CFG_INC:   inc_reg   <= cfg_data[INC_BITS-1:0];
                CFG_RECIP: recip_reg <= cfg_data[RECIP_BITS-1:0];
                CFG_PW:    pw_reg    <= cfg_data[PW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        wrap_reg       <= wrap_next;
        t_reg          <= t_next;
        arg_reg        <= arg_next;
        sel_reg        <= sel_next;
        neg_reg        <= neg_next;
        v_reg          <= v_next;
        mcand_reg      <= mcand_next;
        acc_reg        <= acc_next;
        lo_reg         <= lo_next;
        out_sample_reg <= out_sample_next;
        out_wrap_reg   <= out_wrap_next;
    end

    `PBLEP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    `PBLEP_ASSERT_AT(a_mul_full_pass, aclk, aresetn,
        (state_reg == ST_MUL1 || state_reg == ST_MUL2) && (state_next != state_reg),
        cnt_reg == CNT_LAST)
    `PBLEP_ASSERT_AT(a_y_bounded, aclk, aresetn, state_reg == ST_CLAMP, y_val <= ONE30_Y)
    `PBLEP_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        (state_reg == ST_FINISH) && (state_next == ST_IDLE), m_tvalid)

endmodule
